@@ hw/rtl/scsa_pkg.sv @@
// ---------------------------------------------------------------------------
// scsa_pkg
// shared types and codes of the size class slab allocator
// ---------------------------------------------------------------------------
`default_nettype none
package scsa_pkg;

	// result status codes
	localparam logic [1:0] STATUS_ALLOC   = 2'd0;
	localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
	localparam logic [1:0] STATUS_NO_POOL = 2'd2;
	localparam logic [1:0] STATUS_FREED   = 2'd3;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_BLOCK_BYTES  = 2'd0;
	localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
	localparam logic [1:0] REG_TOP_LEVEL    = 2'd2;

	// classifier status toward the sequencer
	typedef struct packed {
		logic done;
		logic too_big;
	} cls_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/size_class_slab_allocator.sv @@
// ---------------------------------------------------------------------------
// size_class_slab_allocator
// slab allocator with power-of-two size classes and per-pool free lists
// ---------------------------------------------------------------------------
// after reset the block runs a clearing pass over the link memory, one entry
// a cycle, over all 2**(class bits + pool bits + block bits) entries (4096 at
// the default sizes), with s_axis_tready low. an allocate item is accepted,
// then goes through the class search (one shift and compare per class,
// stopping at the top class), then probes the head memory pool by pool (a
// head read and a check per pool, or a pool opening when a new pool is
// opened), then the link read and the output load. a free item is accepted,
// then takes a head read, a link and head write and the output load; a
// rejected free goes from the accept straight to the output load. the output
// load waits while the output register holds an item that is not taken. one
// item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
`default_nettype none
module size_class_slab_allocator #(
	parameter int LEVELS          = 8,
	parameter int MAX_POOLS       = 8,
	parameter int BLOCKS_PER_POOL = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write port
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	// request items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // request_len, free_level, free_pool, free_block
	input  wire         s_axis_tuser,  // operation
	// result items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,  // level, pool, block, zero fill
	output logic [1:0]  m_axis_tuser   // status
);
	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PW    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
	localparam int POW   = $clog2(MAX_POOLS + 1);
	localparam int BW    = $clog2(BLOCKS_PER_POOL);
	localparam int LKW   = $clog2(BLOCKS_PER_POOL + 1);
	localparam int HAW   = LW + PW;
	localparam int AW    = HAW + BW;
	localparam int HEADS = 1 << HAW;
	localparam int LINKS = 1 << AW;
	localparam logic [LKW-1:0] EMPTY = LKW'(BLOCKS_PER_POOL);

	typedef enum logic [9:0] {
		ST_CLR  = 10'b0000000001,
		ST_IDLE = 10'b0000000010,
		ST_CLS  = 10'b0000000100,
		ST_SRD  = 10'b0000001000,
		ST_SCHK = 10'b0000010000,
		ST_POP  = 10'b0000100000,
		ST_LNK  = 10'b0001000000,
		ST_FRD  = 10'b0010000000,
		ST_FHD  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] block_bytes_q;
	logic [7:0]  header_bytes_q;
	logic [2:0]  top_level_q;
	logic [LW-1:0] eff_top;

	// work registers
	logic [AW-1:0]  clr_q;
	logic [LW-1:0]  lv_q;
	logic [POW-1:0] pl_q;
	logic [BW-1:0]  bk_q;
	logic [POW-1:0] popen_q [LEVELS];

	// pending result
	logic [1:0] res_status_q;
	logic [2:0] res_level_q;
	logic [2:0] res_pool_q;
	logic [5:0] res_block_q;

	// request fields
	logic [19:0] in_len;
	logic [2:0]  in_level;
	logic [2:0]  in_pool;
	logic [5:0]  in_block;
	logic        free_ok;

	// memories
	logic [LKW-1:0] head_mem [HEADS];
	logic [LKW-1:0] link_mem [LINKS];
	logic [LKW-1:0] head_rd_q;
	logic [LKW-1:0] link_rd_q;
	logic           head_we, link_we;
	logic [HAW-1:0] head_wa, head_ra;
	logic [AW-1:0]  link_wa, link_ra;
	logic [LKW-1:0] head_wd, link_wd;

	// classifier
	scsa_pkg::cls_stat_t cstat;
	logic [LW-1:0]       cls;
	logic                cstart;

	logic [HAW-1:0] cur_head;
	logic [POW-1:0] cur_open;
	logic           out_free;

	assign in_len   = s_axis_tdata[19:0];
	assign in_level = s_axis_tdata[22:20];
	assign in_pool  = s_axis_tdata[25:23];
	assign in_block = s_axis_tdata[31:26];

	assign eff_top = (int'(top_level_q) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(top_level_q);

	// a bad handle is answered but leaves the lists alone
	always_comb begin
		free_ok = 1'b0;
		if (int'(in_level) <= int'(eff_top) && int'(in_block) < BLOCKS_PER_POOL) begin
			free_ok = int'(in_pool) < int'(popen_q[LW'(in_level)]);
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign cstart        = s_axis_tvalid && s_axis_tready && s_axis_tuser == scsa_pkg::OP_ALLOC;
	assign cur_head      = {lv_q, pl_q[PW-1:0]};
	assign cur_open      = popen_q[lv_q];
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	scsa_classify #(
		.LEVELS(LEVELS)
	) u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cstart),
		.request_len (in_len),
		.block_bytes (block_bytes_q),
		.header_bytes(header_bytes_q),
		.eff_top     (eff_top),
		.stat        (cstat),
		.cls         (cls)
	);

	// memory port control
	always_comb begin
		head_we = 1'b0;
		head_wa = cur_head;
		head_wd = link_rd_q;
		head_ra = cur_head;
		link_we = 1'b0;
		link_wa = {cur_head, bk_q};
		link_wd = head_rd_q;
		link_ra = {cur_head, bk_q};
		case (state_q)
			ST_CLR: begin
				// heads: block zero for pool zero, empty elsewhere
				head_we = clr_q[AW-1:HAW] == '0;
				head_wa = clr_q[HAW-1:0];
				head_wd = (clr_q[PW-1:0] == '0) ? '0 : EMPTY;
				// links: each block to the next
				link_we = 1'b1;
				link_wa = clr_q;
				link_wd = LKW'(clr_q[BW-1:0]) + LKW'(1);
			end
			ST_LNK: begin
				head_we = 1'b1;
			end
			ST_FHD: begin
				link_we = 1'b1;
				head_we = 1'b1;
				head_wd = LKW'(bk_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= link_mem[link_ra];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q  <= 16'd80;
			header_bytes_q <= 8'd32;
			top_level_q    <= 3'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				scsa_pkg::REG_BLOCK_BYTES:  block_bytes_q  <= cfg_data;
				scsa_pkg::REG_HEADER_BYTES: header_bytes_q <= cfg_data[7:0];
				scsa_pkg::REG_TOP_LEVEL:    top_level_q    <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				popen_q[i] <= POW'(1);
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser == scsa_pkg::OP_FREE) begin
							state_q <= free_ok ? ST_FRD : ST_OUT;
						end else begin
							state_q <= ST_CLS;
						end
					end
				end
				ST_CLS: begin
					if (cstat.done) begin
						state_q <= cstat.too_big ? ST_OUT : ST_SRD;
					end
				end
				ST_SRD: begin
					if (pl_q >= cur_open) begin
						if (int'(cur_open) >= MAX_POOLS) begin
							state_q <= ST_OUT;
						end else begin
							// open the next pool, its list is still in block order
							popen_q[lv_q] <= cur_open + POW'(1);
							state_q       <= ST_POP;
						end
					end else begin
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					state_q <= (head_rd_q != EMPTY) ? ST_POP : ST_SRD;
				end
				ST_POP:  state_q <= ST_LNK;
				ST_LNK:  state_q <= ST_OUT;
				ST_FRD:  state_q <= ST_FHD;
				ST_FHD:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// work and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lv_q         <= LW'(in_level);
				pl_q         <= POW'(in_pool);
				bk_q         <= BW'(in_block);
				res_status_q <= scsa_pkg::STATUS_FREED;
				res_level_q  <= in_level;
				res_pool_q   <= in_pool;
				res_block_q  <= in_block;
			end
			ST_CLS: begin
				lv_q         <= cls;
				pl_q         <= '0;
				res_status_q <= scsa_pkg::STATUS_TOO_BIG;
				res_level_q  <= 3'd0;
				res_pool_q   <= 3'd0;
				res_block_q  <= 6'd0;
			end
			ST_SRD: begin
				bk_q         <= '0;
				res_status_q <= scsa_pkg::STATUS_NO_POOL;
				res_level_q  <= 3'(lv_q);
				res_pool_q   <= 3'd0;
				res_block_q  <= 6'd0;
			end
			ST_SCHK: begin
				if (head_rd_q != EMPTY) begin
					bk_q <= head_rd_q[BW-1:0];
				end else begin
					pl_q <= pl_q + POW'(1);
				end
			end
			ST_LNK: begin
				res_status_q <= scsa_pkg::STATUS_ALLOC;
				res_level_q  <= 3'(lv_q);
				res_pool_q   <= 3'(pl_q);
				res_block_q  <= 6'(bk_q);
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_axis_tuser <= res_status_q;
			m_axis_tdata <= {4'd0, res_block_q, res_pool_q, res_level_q};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/scsa_classify.sv @@
// ---------------------------------------------------------------------------
// scsa_classify
// size class search: one shift and compare per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module scsa_classify #(
	parameter int LEVELS = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [19:0]                           request_len,
	input  wire  [15:0]                           block_bytes,
	input  wire  [7:0]                            header_bytes,
	input  wire  [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] eff_top,
	output scsa_pkg::cls_stat_t                   stat,
	output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] cls
);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = (16 + LEVELS > 21) ? 16 + LEVELS : 21;

	logic          busy_q;
	logic [20:0]   sm1_q;
	logic [CW-1:0] dsh_q;
	logic [LW-1:0] cls_q;
	logic [20:0]   sum;
	logic [15:0]   div;
	logic          ge;

	assign sum = 21'(request_len) + 21'(header_bytes);
	assign div = (block_bytes == 16'd0) ? 16'd1 : block_bytes;
	assign ge  = CW'(sm1_q) >= dsh_q;

	assign stat.done    = busy_q && (!ge || cls_q == eff_top);
	assign stat.too_big = ge;
	assign cls          = cls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (stat.done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sm1_q <= (sum == 21'd0) ? 21'd0 : sum - 21'd1;
			dsh_q <= CW'(div) << 1;
			cls_q <= '0;
		end else if (busy_q && ge && cls_q != eff_top) begin
			cls_q <= cls_q + LW'(1);
			dsh_q <= dsh_q << 1;
		end
	end

endmodule
`default_nettype wire
